[hdl/pfa_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfa_pkg: shared types and constants for the page frame allocator
// Request/result payloads, operation and status codes, sequencer states.
// ----------------------------------------------------------------------------
package pfa_pkg;

    localparam int NUM_WORDS_DEF = 1024;
    localparam int WORD_BITS     = 32;
    localparam int WIU_W         = 11;

    localparam logic [WIU_W-1:0] WIU_RESET = 11'd1024;
    localparam logic [2:0]       REG_WIU_ADDR = 3'd0;

    typedef enum logic [1:0] {
        OP_ALLOC         = 2'd0,
        OP_FREE          = 2'd1,
        OP_RESERVE_RANGE = 2'd2,
        OP_FREE_RANGE    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NONE_FREE = 2'd1,
        ST_RANGE     = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_READ,
        S_EVAL,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]  operation;
        logic [14:0] page_first;
        logic [15:0] page_end;
    } t_in_item;

    typedef struct packed {
        logic [14:0] page_number;
        logic [1:0]  status;
    } t_out_item;

    // bit unit command: inclusive bit span of the range mask
    typedef struct packed {
        logic [4:0] lo;
        logic [4:0] hi;
    } t_bit_cmd;

    typedef struct packed {
        logic                 found;
        logic [4:0]           idx;
        logic [WORD_BITS-1:0] zbit;
        logic [WORD_BITS-1:0] mask;
    } t_bit_res;

endpackage
`default_nettype wire

[hdl/pfa_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfa_ram: generic single-port RAM
// One address per cycle, write or read, registered read data (read-first).
// ----------------------------------------------------------------------------
module pfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

[hdl/pfa_bitunit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfa_bitunit: shared bit unit of the sequencer
// Finds the lowest free bit of a bitmap word and builds range masks.
// ----------------------------------------------------------------------------
module pfa_bitunit (
    input  wire pfa_pkg::t_bit_cmd                i_cmd,
    input  wire logic [pfa_pkg::WORD_BITS-1:0]    i_word,
    output pfa_pkg::t_bit_res                     o_res
);

    logic [pfa_pkg::WORD_BITS-1:0] ones;
    logic [pfa_pkg::WORD_BITS-1:0] zbit;
    logic [4:0]                    idx;

    assign ones = '1;

    // isolate lowest clear bit
    assign zbit = ~i_word & (i_word + 32'd1);

    always_comb begin
        idx = '0;
        for (int i = 0; i < pfa_pkg::WORD_BITS; i++) begin
            if (zbit[i]) begin
                idx = 5'(i);
            end
        end
    end

    assign o_res.found = (i_word != ones);
    assign o_res.idx   = idx;
    assign o_res.zbit  = zbit;
    assign o_res.mask  = (ones << i_cmd.lo) & (ones >> (5'd31 - i_cmd.hi));

endmodule
`default_nettype wire

[hdl/pfa_seq.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfa_seq: word-walking sequencer
// Fills the bitmap with ones after reset, then runs one request at a time over the
// bitmap words through the shared bit unit.
// ----------------------------------------------------------------------------
module pfa_seq #(
    parameter int NUM_WORDS = pfa_pkg::NUM_WORDS_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_start,
    input  wire pfa_pkg::t_in_item                      i_req,
    input  wire logic [pfa_pkg::WIU_W-1:0]              i_wiu,
    input  wire logic                                   i_slot_free,
    output logic                                        o_busy,
    output logic                                        o_done,
    output pfa_pkg::t_out_item                          o_res,
    output logic                                        o_ram_we,
    output logic [((NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1)-1:0] o_ram_addr,
    output logic [pfa_pkg::WORD_BITS-1:0]               o_ram_wdata,
    input  wire logic [pfa_pkg::WORD_BITS-1:0]          i_ram_rdata
);

    localparam int AW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int CW = (AW + 6 > 17) ? AW + 6 : 17;
    localparam logic [CW-1:0] TOTAL_PAGES = CW'(NUM_WORDS * pfa_pkg::WORD_BITS);
    localparam logic [CW-1:0] WORDS_C     = CW'(NUM_WORDS);
    localparam logic [AW-1:0] LAST_WORD   = AW'(NUM_WORDS - 1);

    pfa_pkg::t_state  r_state, n_state;
    logic [AW-1:0]    r_word, n_word;
    logic [AW-1:0]    r_first_word, n_first_word;
    logic [AW-1:0]    r_last, n_last;
    logic [4:0]       r_lo, n_lo;
    logic [4:0]       r_hi, n_hi;
    pfa_pkg::t_op     r_op, n_op;
    logic [14:0]      r_page, n_page;
    pfa_pkg::t_status r_status, n_status;

    logic [CW-1:0]    first_c;
    logic [CW-1:0]    end_c;
    logic [CW-1:0]    end_m1;
    logic [CW-1:0]    limit;
    logic [CW-1:0]    limit_m1;
    logic [AW+4:0]    found_page;

    pfa_pkg::t_bit_cmd bit_cmd;
    pfa_pkg::t_bit_res bit_res;

    pfa_bitunit u_bitunit (
        .i_cmd  (bit_cmd),
        .i_word (i_ram_rdata),
        .o_res  (bit_res)
    );

    assign first_c    = CW'(i_req.page_first);
    assign end_c      = CW'(i_req.page_end);
    assign end_m1     = end_c - CW'(1);
    assign limit      = (CW'(i_wiu) > WORDS_C) ? WORDS_C : CW'(i_wiu);
    assign limit_m1   = limit - CW'(1);
    assign found_page = {r_word, bit_res.idx};

    // edge words use the request bit bounds, inner words the whole word
    assign bit_cmd.lo = (r_word == r_first_word) ? r_lo : 5'd0;
    assign bit_cmd.hi = (r_word == r_last) ? r_hi : 5'd31;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pfa_pkg::S_INIT;
            r_word  <= '0;
        end else begin
            r_state <= n_state;
            r_word  <= n_word;
        end
    end

    always_ff @(posedge i_clk) begin
        r_first_word <= n_first_word;
        r_last       <= n_last;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_op         <= n_op;
        r_page       <= n_page;
        r_status     <= n_status;
    end

    always_comb begin
        n_state      = r_state;
        n_word       = r_word;
        n_first_word = r_first_word;
        n_last       = r_last;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_op         = r_op;
        n_page       = r_page;
        n_status     = r_status;
        o_ram_we     = 1'b0;
        o_ram_addr   = r_word;
        o_ram_wdata  = i_ram_rdata;
        o_done       = 1'b0;

        unique case (r_state)
            pfa_pkg::S_INIT: begin
                o_ram_we    = 1'b1;
                o_ram_wdata = '1;
                if (r_word == LAST_WORD) begin
                    n_word  = '0;
                    n_state = pfa_pkg::S_IDLE;
                end else begin
                    n_word = r_word + AW'(1);
                end
            end
            pfa_pkg::S_IDLE: begin
                if (i_start) begin
                    n_op     = pfa_pkg::t_op'(i_req.operation);
                    n_page   = '0;
                    n_status = pfa_pkg::ST_OK;
                    unique case (pfa_pkg::t_op'(i_req.operation))
                        pfa_pkg::OP_ALLOC: begin
                            n_word       = '0;
                            n_first_word = '0;
                            n_last       = limit_m1[AW-1:0];
                            n_lo         = 5'd0;
                            n_hi         = 5'd31;
                            if (limit == '0) begin
                                n_status = pfa_pkg::ST_NONE_FREE;
                                n_state  = pfa_pkg::S_DONE;
                            end else begin
                                n_state = pfa_pkg::S_READ;
                            end
                        end
                        pfa_pkg::OP_FREE: begin
                            n_word       = first_c[AW+4:5];
                            n_first_word = first_c[AW+4:5];
                            n_last       = first_c[AW+4:5];
                            n_lo         = first_c[4:0];
                            n_hi         = first_c[4:0];
                            if (first_c >= TOTAL_PAGES) begin
                                n_status = pfa_pkg::ST_RANGE;
                                n_state  = pfa_pkg::S_DONE;
                            end else begin
                                n_state = pfa_pkg::S_READ;
                            end
                        end
                        default: begin
                            n_word       = first_c[AW+4:5];
                            n_first_word = first_c[AW+4:5];
                            n_last       = end_m1[AW+4:5];
                            n_lo         = first_c[4:0];
                            n_hi         = end_m1[4:0];
                            if (end_c <= first_c) begin
                                n_state = pfa_pkg::S_DONE;
                            end else if (end_c > TOTAL_PAGES) begin
                                n_status = pfa_pkg::ST_RANGE;
                                n_state  = pfa_pkg::S_DONE;
                            end else begin
                                n_state = pfa_pkg::S_READ;
                            end
                        end
                    endcase
                end
            end
            pfa_pkg::S_READ: begin
                n_state = pfa_pkg::S_EVAL;
            end
            pfa_pkg::S_EVAL: begin
                if (r_op == pfa_pkg::OP_ALLOC) begin
                    if (bit_res.found) begin
                        o_ram_we    = 1'b1;
                        o_ram_wdata = i_ram_rdata | bit_res.zbit;
                        n_page      = 15'(found_page);
                        n_state     = pfa_pkg::S_DONE;
                    end else if (r_word == r_last) begin
                        n_status = pfa_pkg::ST_NONE_FREE;
                        n_state  = pfa_pkg::S_DONE;
                    end else begin
                        n_word  = r_word + AW'(1);
                        n_state = pfa_pkg::S_READ;
                    end
                end else begin
                    o_ram_we = 1'b1;
                    if (r_op == pfa_pkg::OP_RESERVE_RANGE) begin
                        o_ram_wdata = i_ram_rdata | bit_res.mask;
                    end else begin
                        o_ram_wdata = i_ram_rdata & ~bit_res.mask;
                    end
                    if (r_word == r_last) begin
                        n_state = pfa_pkg::S_DONE;
                    end else begin
                        n_word  = r_word + AW'(1);
                        n_state = pfa_pkg::S_READ;
                    end
                end
            end
            pfa_pkg::S_DONE: begin
                if (i_slot_free) begin
                    o_done  = 1'b1;
                    n_state = pfa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pfa_pkg::S_IDLE;
            end
        endcase
    end

    assign o_busy            = (r_state != pfa_pkg::S_IDLE);
    assign o_res.page_number = r_page;
    assign o_res.status      = r_status;

endmodule
`default_nettype wire

[hdl/bitmap_page_frame_allocator.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_page_frame_allocator: first-fit bitmap page frame allocator
// One bit per 4 KiB page frame (1 = reserved), NUM_WORDS words of 32 bits.
// ----------------------------------------------------------------------------
// Usage:
//  - Request channel (i_in_valid / o_in_stall / i_in_data): operation
//    allocate, free page, reserve range [page_first, page_end) or free range.
//    Pages are frame numbers; divide byte addresses by 4096 beforehand.
//  - Result channel (o_out_valid / i_out_stall / o_out_data): exactly one
//    result per request: page_number (allocate only) and status.
//  - APB register 0 (words_in_use) limits the words searched by allocate.
//    Write it only while no request is in flight.
//  - Timing: one request at a time; each bitmap word visited takes a
//    registered RAM read (S_READ), then a modify/write through the bit
//    unit (S_EVAL), plus entry/exit through S_IDLE and S_DONE. Allocate
//    visits words up to the first with a free page; ranges visit every
//    word covered. Out-of-range and empty requests skip the word walk.
//  - Reset: an init pass writes all ones to every word (NUM_WORDS words,
//    1024 by default); requests stall until it is done.
//  - A stalled result sits in the output register; the next request is
//    accepted and processed, and only its completion waits for the slot.
// ----------------------------------------------------------------------------
module bitmap_page_frame_allocator #(
    parameter int NUM_WORDS = pfa_pkg::NUM_WORDS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // request channel
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire pfa_pkg::t_in_item    i_in_data,
    // result channel
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output pfa_pkg::t_out_item        o_out_data,
    // APB configuration port
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [2:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic      [31:0]          prdata,
    output logic                      pready
);

    localparam int AW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

    logic [pfa_pkg::WIU_W-1:0]     r_wiu;
    logic                          r_out_valid;
    pfa_pkg::t_out_item            r_out_data;

    logic                          busy;
    logic                          done;
    logic                          slot_free;
    pfa_pkg::t_out_item            seq_res;
    logic                          ram_we;
    logic [AW-1:0]                 ram_addr;
    logic [pfa_pkg::WORD_BITS-1:0] ram_wdata;
    logic [pfa_pkg::WORD_BITS-1:0] ram_rdata;

    // ---- configuration register ----
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wiu <= pfa_pkg::WIU_RESET;
        end else if (psel && penable && pwrite && (paddr == pfa_pkg::REG_WIU_ADDR)) begin
            r_wiu <= pwdata[pfa_pkg::WIU_W-1:0];
        end
    end

    assign prdata = (paddr == pfa_pkg::REG_WIU_ADDR) ? 32'(r_wiu) : 32'd0;

    // ---- sequencer: owns the bitmap walk ----
    pfa_seq #(
        .NUM_WORDS (NUM_WORDS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_in_valid && !busy),
        .i_req       (i_in_data),
        .i_wiu       (r_wiu),
        .i_slot_free (slot_free),
        .o_busy      (busy),
        .o_done      (done),
        .o_res       (seq_res),
        .o_ram_we    (ram_we),
        .o_ram_addr  (ram_addr),
        .o_ram_wdata (ram_wdata),
        .i_ram_rdata (ram_rdata)
    );

    // ---- bitmap storage ----
    pfa_ram #(
        .WIDTH (pfa_pkg::WORD_BITS),
        .DEPTH (NUM_WORDS)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    assign o_in_stall = busy;

    // ---- output register ----
    // slot frees when empty or when the current result is taken this cycle
    assign slot_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_out_data <= seq_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
`default_nettype wire
